[src/nir_pkg.sv]
// ----------------------------------------------------------------------------
// nir_pkg
// Shared types and codes for the NEC infrared remote decoder.
// ----------------------------------------------------------------------------
package nir_pkg;

	// input request: one edge interval or one millisecond tick
	typedef struct packed {
		logic        func;
		logic [15:0] interval_us;
		logic        display_mode;
		logic        standby;
		logic        repeat_enable;
	} in_item_t;

	// result request: one key event
	typedef struct packed {
		logic [1:0] action;
		logic [2:0] key_class;
		logic [7:0] raw_code;
		logic [7:0] key_count;
		logic       beep;
		logic       last;
	} out_item_t;

	// interval classes handed from front to back
	localparam logic [2:0] CLS_NONE   = 3'd0;
	localparam logic [2:0] CLS_ZERO   = 3'd1;
	localparam logic [2:0] CLS_ONE    = 3'd2;
	localparam logic [2:0] CLS_REPEAT = 3'd3;
	localparam logic [2:0] CLS_LEADER = 3'd4;
	localparam logic [2:0] CLS_TICK   = 3'd5;

	typedef struct packed {
		logic [2:0] cls;
		logic       display_mode;
		logic       standby;
		logic       repeat_enable;
	} cmd_t;

	// event actions
	localparam logic [1:0] ACT_DOWN = 2'd0;
	localparam logic [1:0] ACT_UP   = 2'd1;
	localparam logic [1:0] ACT_LONG = 2'd2;

	// key classes
	localparam logic [2:0] KEY_POWER    = 3'd0;
	localparam logic [2:0] KEY_LEFT     = 3'd1;
	localparam logic [2:0] KEY_RIGHT    = 3'd2;
	localparam logic [2:0] KEY_OK       = 3'd3;
	localparam logic [2:0] KEY_SELECT   = 3'd4;
	localparam logic [2:0] KEY_MENU     = 3'd5;
	localparam logic [2:0] KEY_UNMAPPED = 3'd6;

	// data bytes of the mapped remote keys
	localparam logic [7:0] CODE_OK    = 8'h01;
	localparam logic [7:0] CODE_POWER = 8'h02;
	localparam logic [7:0] CODE_RIGHT = 8'h03;
	localparam logic [7:0] CODE_MENU  = 8'h04;
	localparam logic [7:0] CODE_LEFT  = 8'h05;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_CODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_THRESH = 3'd4;

endpackage

[src/nec_ir_remote_decoder.sv]
// ----------------------------------------------------------------------------
// nec_ir_remote_decoder
// NEC infrared remote decoder: edge intervals and ms ticks in, key events out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and raise push; the request is taken on a clock
//   edge with push high and full low. func selects a falling edge (with its
//   interval in us) or a one-millisecond tick.
//   Result queue: while empty is low, result holds the oldest key event; raise
//   pop to take it. One input causes zero, one or two events; last marks the
//   final one of each input.
//   Config: cfg_valid with cfg_index / cfg_data; cfg_ready is always high.
//   Write only while the block is idle.
// Timing:
//   An accepted input goes from the command queue through the back end into
//   the event queue, from which its first event shows on the result port.
//   One input per cycle is sustained while results are popped every cycle and
//   inputs make at most one event each; an auto-repeat pair leaves one event
//   per pop. The back end retires one command a cycle whenever the event queue
//   has room for a pair. When pop stays low the event queue fills, the back end
//   stops, the command queue fills and full rises. Nothing is dropped.
// Reset: arst_n clears all decoder state and both queues and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nec_ir_remote_decoder #(
	parameter int CMD_DEPTH = 4,
	parameter int EVQ_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  nir_pkg::in_item_t             item,
	output logic                          empty,
	input  logic                          pop,
	output nir_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import nir_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int EV_W  = $bits(out_item_t);
	localparam int CCW   = $clog2(CMD_DEPTH) + 1;
	localparam int ECW   = $clog2(EVQ_DEPTH) + 1;

	logic [CCW-1:0]   cmdq_count;
	logic [1:0]       cmdq_wr_n;
	cmd_t             cmd_in;
	logic [CMD_W-1:0] cmd_raw;
	cmd_t             cmd_out;
	logic             cmd_pop;
	logic [ECW-1:0]   evq_count;
	logic             ev_room;
	logic [1:0]       ev_n;
	out_item_t        ev0;
	out_item_t        ev1;
	logic [EV_W-1:0]  ev_raw;
	logic             out_pop;

	assign cfg_ready = 1'b1;

	nir_front #(.DEPTH(CMD_DEPTH)) u_front (
		.push       (push),
		.full       (full),
		.item       (item),
		.cmdq_count (cmdq_count),
		.wr_n       (cmdq_wr_n),
		.cmd        (cmd_in)
	);

	nir_fifo #(.W(CMD_W), .DEPTH(CMD_DEPTH)) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_n     (cmdq_wr_n),
		.wr_data0 (cmd_in),
		.wr_data1 (cmd_in),
		.rd       (cmd_pop),
		.rd_data  (cmd_raw),
		.count    (cmdq_count)
	);

	assign cmd_out = cmd_t'(cmd_raw);
	assign ev_room = (evq_count <= ECW'(EVQ_DEPTH - 2));

	nir_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmdq_count != '0),
		.cmd       (cmd_out),
		.ev_room   (ev_room),
		.cmd_pop   (cmd_pop),
		.ev_n      (ev_n),
		.ev0       (ev0),
		.ev1       (ev1)
	);

	assign empty   = (evq_count == '0);
	assign out_pop = pop & ~empty;

	nir_fifo #(.W(EV_W), .DEPTH(EVQ_DEPTH)) u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_n     (ev_n),
		.wr_data0 (ev0),
		.wr_data1 (ev1),
		.rd       (out_pop),
		.rd_data  (ev_raw),
		.count    (evq_count)
	);

	assign result = out_item_t'(ev_raw);

endmodule

[src/nir_fifo.sv]
// ----------------------------------------------------------------------------
// nir_fifo
// Small queue taking zero, one or two entries per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module nir_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 wr_n,
	input  logic [W-1:0]               wr_data0,
	input  logic [W-1:0]               wr_data1,
	input  logic                       rd,
	output logic [W-1:0]               rd_data,
	output logic [$clog2(DEPTH):0]     count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wp_q] <= wr_data0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wp_q + 1'b1] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(wr_n);
			rp_q    <= rp_q + AW'(rd);
			count_q <= count_q + CW'(wr_n) - CW'(rd);
		end
	end

	assign rd_data = mem_q[rp_q];
	assign count   = count_q;

endmodule

[src/nir_front.sv]
// ----------------------------------------------------------------------------
// nir_front
// Accepts input requests and sorts edge intervals into pulse classes.
// ----------------------------------------------------------------------------
module nir_front #(
	parameter int DEPTH = 4
) (
	input  logic                   push,
	output logic                   full,
	input  nir_pkg::in_item_t      item,
	input  logic [$clog2(DEPTH):0] cmdq_count,
	output logic [1:0]             wr_n,
	output nir_pkg::cmd_t          cmd
);
	import nir_pkg::*;

	localparam int CW = $clog2(DEPTH) + 1;

	// pulse windows in us, both ends exclusive
	localparam logic [15:0] ZERO_LO   = 16'd1000;
	localparam logic [15:0] ZERO_HI   = 16'd1300;
	localparam logic [15:0] ONE_LO    = 16'd2100;
	localparam logic [15:0] ONE_HI    = 16'd2400;
	localparam logic [15:0] REPEAT_LO = 16'd10500;
	localparam logic [15:0] LEADER_LO = 16'd12500;
	localparam logic [15:0] LEADER_HI = 16'd14500;

	logic [15:0] t;

	assign t    = item.interval_us;
	assign full = (cmdq_count == CW'(DEPTH));
	assign wr_n = {1'b0, push & ~full};

	always_comb begin
		cmd.display_mode  = item.display_mode;
		cmd.standby       = item.standby;
		cmd.repeat_enable = item.repeat_enable;
		if (item.func) begin
			cmd.cls = CLS_TICK;
		end else if (t > LEADER_LO && t < LEADER_HI) begin
			cmd.cls = CLS_LEADER;
		end else if (t > REPEAT_LO && t < LEADER_LO) begin
			cmd.cls = CLS_REPEAT;
		end else if (t > ONE_LO && t < ONE_HI) begin
			cmd.cls = CLS_ONE;
		end else if (t > ZERO_LO && t < ZERO_HI) begin
			cmd.cls = CLS_ZERO;
		end else begin
			cmd.cls = CLS_NONE;
		end
	end

endmodule

[src/nir_back.sv]
// ----------------------------------------------------------------------------
// nir_back
// Frame assembly, key hold / repeat / release tracking and event generation.
// ----------------------------------------------------------------------------
module nir_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [nir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              cmd_valid,
	input  nir_pkg::cmd_t                     cmd,
	input  logic                              ev_room,
	output logic                              cmd_pop,
	output logic [1:0]                        ev_n,
	output nir_pkg::out_item_t                ev0,
	output nir_pkg::out_item_t                ev1
);
	import nir_pkg::*;

	localparam logic [5:0] EI_LAST_SHIFT = 6'd33;
	localparam logic [5:0] EI_FRAME_DONE = 6'd34;
	localparam logic [5:0] EI_MAX        = 6'd37;

	logic [15:0] cc_q;
	logic [3:0]  rtk_q;
	logic [4:0]  td_q;
	logic [7:0]  lpr_q;
	logic [7:0]  thr_q;

	logic [5:0]  ei_q, ei;
	logic [31:0] sw_q, sw;
	logic        held_q, held;
	logic [3:0]  rt_q, rt;
	logic [7:0]  rc_q, rc;
	logic        armed_q, armed;
	logic [4:0]  ps_q, ps;
	logic [2:0]  hc_q, hc;
	logic [7:0]  hr_q, hr;
	logic        fresh;

	function automatic logic [2:0] map_class(input logic [7:0] code, input logic disp);
		case (code)
			CODE_POWER: map_class = KEY_POWER;
			CODE_LEFT:  map_class = KEY_LEFT;
			CODE_RIGHT: map_class = KEY_RIGHT;
			CODE_OK:    map_class = disp ? KEY_SELECT : KEY_OK;
			CODE_MENU:  map_class = KEY_MENU;
			default:    map_class = KEY_UNMAPPED;
		endcase
	endfunction

	function automatic out_item_t mk_ev(input logic [1:0] act, input logic [2:0] cls,
			input logic [7:0] raw, input logic [7:0] cnt, input logic bp);
		out_item_t e;
		e.action    = act;
		e.key_class = cls;
		e.raw_code  = raw;
		e.key_count = cnt;
		e.beep      = bp;
		e.last      = 1'b0;
		return e;
	endfunction

	// one command per cycle while the event queue can take a pair
	assign cmd_pop = cmd_valid & ev_room;

	always_comb begin
		ei    = ei_q;
		sw    = sw_q;
		held  = held_q;
		rt    = rt_q;
		rc    = rc_q;
		armed = armed_q;
		ps    = ps_q;
		hc    = hc_q;
		hr    = hr_q;
		fresh = 1'b0;
		ev_n  = 2'd0;
		ev0   = '0;
		ev1   = '0;
		if (cmd_pop) begin
			if (cmd.cls == CLS_TICK) begin
				ps = ps_q + 5'd1;
				// divide of zero compares true every tick
				if (ps >= td_q) begin
					ps = '0;
					if (rt != 4'd0) begin
						rt = rt - 4'd1;
					end
					if (rt == 4'd0 && held) begin
						held = 1'b0;
						if (hc == KEY_POWER && armed) begin
							armed = 1'b0;
							ev0   = mk_ev(ACT_LONG, hc, hr, lpr_q, 1'b0);
						end else begin
							ev0 = mk_ev(ACT_UP, hc, hr, 8'd0, 1'b0);
						end
						ev_n = 2'd1;
					end
				end
			end else begin
				if (cmd.cls == CLS_LEADER) begin
					ei = 6'd1;
					sw = '0;
				end
				if (ei < EI_FRAME_DONE) begin
					if (cmd.cls == CLS_ZERO || cmd.cls == CLS_ONE) begin
						if (cmd.cls == CLS_ONE) begin
							sw[31] = 1'b1;
						end
						// last bit lands in place, no shift
						if (ei < EI_LAST_SHIFT) begin
							sw = sw >> 1;
						end
					end
				end else if (cmd.cls == CLS_REPEAT && held) begin
					if (rc != 8'hFF) begin
						rc = rc + 8'd1;
					end
					rt = rtk_q;
					if (cmd.repeat_enable && (hc == KEY_LEFT || hc == KEY_RIGHT) &&
							rc > thr_q) begin
						ev0  = mk_ev(ACT_DOWN, hc, hr, 8'd0, 1'b0);
						ev1  = mk_ev(ACT_UP, hc, hr, 8'd0, 1'b0);
						ev_n = 2'd2;
					end else if (hc == KEY_POWER && rc == lpr_q) begin
						rt    = '0;
						rc    = '0;
						armed = 1'b1;
					end
				end
				if (ei < EI_MAX) begin
					ei = ei + 6'd1;
				end
				if (ei == EI_FRAME_DONE) begin
					if (sw[15:0] == cc_q && ~sw[31:24] == sw[23:16]) begin
						fresh = (rt == 4'd0);
						held  = 1'b1;
						rt    = rtk_q;
						rc    = '0;
						hr    = sw[23:16];
						hc    = map_class(sw[23:16], cmd.display_mode);
						ev0   = mk_ev(ACT_DOWN, hc, hr, 8'd0, ~cmd.standby & fresh);
						ev_n  = 2'd1;
					end else begin
						held = 1'b0;
						sw   = '0;
					end
				end
			end
		end
		if (ev_n == 2'd1) begin
			ev0.last = 1'b1;
		end
		if (ev_n == 2'd2) begin
			ev1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ei_q    <= '0;
			sw_q    <= '0;
			held_q  <= 1'b0;
			rt_q    <= '0;
			rc_q    <= '0;
			armed_q <= 1'b0;
			ps_q    <= '0;
			hc_q    <= '0;
			hr_q    <= '0;
		end else begin
			ei_q    <= ei;
			sw_q    <= sw;
			held_q  <= held;
			rt_q    <= rt;
			rc_q    <= rc;
			armed_q <= armed;
			ps_q    <= ps;
			hc_q    <= hc;
			hr_q    <= hr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= 16'hFF80;
			rtk_q <= 4'd8;
			td_q  <= 5'd18;
			lpr_q <= 8'd20;
			thr_q <= 8'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CUSTOM_CODE:   cc_q  <= cfg_data;
				REG_RELEASE_TICKS: rtk_q <= cfg_data[3:0];
				REG_TICK_DIVIDE:   td_q  <= cfg_data[4:0];
				REG_LONG_PRESS:    lpr_q <= cfg_data[7:0];
				REG_REPEAT_THRESH: thr_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[src/nir_checker.sv]
// ----------------------------------------------------------------------------
// nir_checker
// Port-level checks on the decoder result queue, bound to the top level.
// ----------------------------------------------------------------------------
module nir_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input nir_pkg::out_item_t result
);
	import nir_pkg::*;

	// a waiting result is not withdrawn or changed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// queue comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

	// auto-repeat pairs are queued together: the up follows right behind the down
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && result.action == ACT_DOWN && !result.last |=>
			!empty && result.action == ACT_UP && result.last)
		else $error("auto-repeat pair split");

	// beep only on a key down, count only on a long-press release
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!result.beep || result.action == ACT_DOWN) &&
			(result.key_count == 8'd0 || result.action == ACT_LONG))
		else $error("inconsistent result fields");

endmodule

bind nec_ir_remote_decoder nir_checker u_nir_checker (.*);

[verif/nec_ir_remote_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_remote_decoder_checker
// Passive scoreboard for the IR decoder: tracks register writes, runs its own
// decoder state for every accepted request and compares each popped key event
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module nec_ir_remote_decoder_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  nir_pkg::in_item_t             item,
	input  logic                          empty,
	input  logic                          pop,
	input  nir_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	output int                            fails,
	output int                            waiting,
	output int                            events_seen
);
	import nir_pkg::*;

	localparam int ZERO_LO   = 1000;
	localparam int ZERO_HI   = 1300;
	localparam int ONE_LO    = 2100;
	localparam int ONE_HI    = 2400;
	localparam int REPEAT_LO = 10500;
	localparam int LEADER_LO = 12500;
	localparam int LEADER_HI = 14500;
	localparam int FRAME_END = 34;
	localparam int EDGE_CAP  = 37;
	localparam int MAX_PRINT = 40;

	// register copies
	logic [15:0] custom_r;
	logic [3:0]  rel_ticks_r;
	logic [4:0]  divide_r;
	logic [7:0]  long_press_r;
	logic [7:0]  threshold_r;

	// decoder state
	logic [5:0]  edge_idx;
	logic [31:0] frame_bits;
	logic        key_held;
	logic [3:0]  rel_timer;
	logic [7:0]  rep_cnt;
	logic        lp_armed;
	logic [4:0]  tick_pre;
	logic [2:0]  held_class;
	logic [7:0]  held_raw;

	out_item_t pending_events[$];
	int n_fail = 0;
	int n_events = 0;

	task automatic flag(input string what);
		n_fail++;
		if (n_fail <= MAX_PRINT)
			$display("[%0t] checker: %s", $time, what);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag($sformatf("event %0d field %s: got %0d, want %0d", n_events, name, got, want));
	endtask

	function automatic logic [2:0] class_of(input logic [7:0] code, input logic disp);
		case (code)
			CODE_POWER: return KEY_POWER;
			CODE_LEFT:  return KEY_LEFT;
			CODE_RIGHT: return KEY_RIGHT;
			CODE_OK:    return disp ? KEY_SELECT : KEY_OK;
			CODE_MENU:  return KEY_MENU;
			default:    return KEY_UNMAPPED;
		endcase
	endfunction

	function automatic out_item_t key_event(input logic [1:0] act, input logic [7:0] cnt,
			input logic bp);
		out_item_t ev;
		ev.action    = act;
		ev.key_class = held_class;
		ev.raw_code  = held_raw;
		ev.key_count = cnt;
		ev.beep      = bp;
		ev.last      = 1'b0;
		return ev;
	endfunction

	task automatic reset_model();
		custom_r     = 16'hFF80;
		rel_ticks_r  = 4'd8;
		divide_r     = 5'd18;
		long_press_r = 8'd20;
		threshold_r  = 8'd2;
		edge_idx     = '0;
		frame_bits   = '0;
		key_held     = 1'b0;
		rel_timer    = '0;
		rep_cnt      = '0;
		lp_armed     = 1'b0;
		tick_pre     = '0;
		held_class   = '0;
		held_raw     = '0;
		pending_events.delete();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		case (idx)
			REG_CUSTOM_CODE:   custom_r     = data;
			REG_RELEASE_TICKS: rel_ticks_r  = data[3:0];
			REG_TICK_DIVIDE:   divide_r     = data[4:0];
			REG_LONG_PRESS:    long_press_r = data[7:0];
			REG_REPEAT_THRESH: threshold_r  = data[7:0];
			default: ;
		endcase
	endtask

	task automatic decode_item(input in_item_t it);
		out_item_t ev[2];
		int n;
		int us;
		logic fresh;
		n = 0;
		if (it.func) begin
			tick_pre = tick_pre + 5'd1;
			// a divide of zero passes every tick
			if (tick_pre >= divide_r) begin
				tick_pre = '0;
				if (rel_timer != 0)
					rel_timer = rel_timer - 4'd1;
				if (rel_timer == 0 && key_held) begin
					key_held = 1'b0;
					if (held_class == KEY_POWER && lp_armed) begin
						lp_armed = 1'b0;
						ev[n] = key_event(ACT_LONG, long_press_r, 1'b0);
					end else begin
						ev[n] = key_event(ACT_UP, 8'd0, 1'b0);
					end
					n++;
				end
			end
		end else begin
			us = it.interval_us;
			if (us > LEADER_LO && us < LEADER_HI) begin
				edge_idx   = 6'd1;
				frame_bits = '0;
			end
			if (edge_idx < FRAME_END) begin
				// bits enter at the top; the final one is not shifted down
				if (us > ZERO_LO && us < ZERO_HI) begin
					if (edge_idx < FRAME_END - 1)
						frame_bits = frame_bits >> 1;
				end else if (us > ONE_LO && us < ONE_HI) begin
					frame_bits[31] = 1'b1;
					if (edge_idx < FRAME_END - 1)
						frame_bits = frame_bits >> 1;
				end
			end else if (us > REPEAT_LO && us < LEADER_LO) begin
				if (key_held) begin
					if (rep_cnt != 8'hFF)
						rep_cnt = rep_cnt + 8'd1;
					rel_timer = rel_ticks_r;
					if (it.repeat_enable && (held_class == KEY_LEFT || held_class == KEY_RIGHT)
							&& rep_cnt > threshold_r) begin
						ev[0] = key_event(ACT_DOWN, 8'd0, 1'b0);
						ev[1] = key_event(ACT_UP, 8'd0, 1'b0);
						n = 2;
					end else if (held_class == KEY_POWER && rep_cnt == long_press_r) begin
						rel_timer = '0;
						rep_cnt   = '0;
						lp_armed  = 1'b1;
					end
				end
			end
			if (edge_idx < EDGE_CAP)
				edge_idx = edge_idx + 6'd1;
			if (edge_idx == FRAME_END) begin
				if (frame_bits[15:0] == custom_r && (~frame_bits[31:24]) == frame_bits[23:16]) begin
					fresh      = (rel_timer == 0);
					key_held   = 1'b1;
					rel_timer  = rel_ticks_r;
					rep_cnt    = '0;
					held_raw   = frame_bits[23:16];
					held_class = class_of(held_raw, it.display_mode);
					ev[n] = key_event(ACT_DOWN, 8'd0, !it.standby && fresh);
					n++;
				end else begin
					key_held   = 1'b0;
					frame_bits = '0;
				end
			end
		end
		if (n > 0)
			ev[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_events.push_back(ev[i]);
	endtask

	task automatic check_event(input out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			flag($sformatf("unexpected key event action %0d class %0d", got.action, got.key_class));
		end else begin
			want = pending_events.pop_front();
			check_field("action", got.action, want.action);
			check_field("key_class", got.key_class, want.key_class);
			check_field("raw_code", got.raw_code, want.raw_code);
			check_field("key_count", got.key_count, want.key_count);
			check_field("beep", got.beep, want.beep);
			check_field("last", got.last, want.last);
		end
		n_events++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			fails       <= 0;
			waiting     <= 0;
			events_seen <= 0;
		end else begin
			if (pop && !empty)
				check_event(result);
			if (cfg_valid && cfg_ready)
				write_reg(cfg_index, cfg_data);
			if (push && !full)
				decode_item(item);
			fails       <= n_fail;
			waiting     <= pending_events.size();
			events_seen <= n_events;
		end
	end

endmodule

[verif/nec_ir_remote_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_remote_decoder_tb
// Drives edge intervals and ms ticks into the IR decoder: boundary intervals,
// then well-formed NEC frames with repeat runs and release timing mixed with
// broken frames and noise, over several register settings and stall patterns.
// The checker beside the block predicts and compares every key event.
// ----------------------------------------------------------------------------
module nec_ir_remote_decoder_tb;
	import nir_pkg::*;

	localparam int LIMIT        = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 170;
	localparam int N_PHASES     = 6;
	localparam int MAX_REPS     = 24;

	localparam int ZERO_LO   = 1000;
	localparam int ZERO_HI   = 1300;
	localparam int ONE_LO    = 2100;
	localparam int ONE_HI    = 2400;
	localparam int REPEAT_LO = 10500;
	localparam int LEADER_LO = 12500;
	localparam int LEADER_HI = 14500;
	localparam int MAPPED_LO = 1;
	localparam int MAPPED_HI = 5;

	typedef struct packed {
		logic [15:0] custom;
		logic [3:0]  rel_ticks;
		logic [4:0]  divide;
		logic [7:0]  long_press;
		logic [7:0]  threshold;
	} reg_set_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 pop       = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = '0;
	in_item_t             item      = '0;
	logic                 full;
	logic                 empty;
	logic                 cfg_ready;
	out_item_t            result;

	int          fails;
	int          waiting;
	int          events_seen;
	int unsigned cycle_cnt  = 0;
	int          items_sent = 0;
	int          send_idle  = 0;
	int          recv_idle  = 0;
	reg_set_t    regs;

	nec_ir_remote_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nec_ir_remote_decoder_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.waiting     (waiting),
		.events_seen (events_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	always @(posedge clk) pop <= arst_n && ($urandom_range(99) >= recv_idle);

	initial begin
		wait (cycle_cnt >= LIMIT);
		$display("nec_ir_remote_decoder_tb: FAIL");
		$finish;
	end

	function automatic logic [15:0] pick_between(input int lo, input int hi);
		return 16'($urandom_range(lo + 1, hi - 1));
	endfunction

	// keeps repeat runs short when a register asks for hundreds
	function automatic int cap_reps(input int n);
		return (n > MAX_REPS) ? MAX_REPS : n;
	endfunction

	// intervals on and next to every class boundary
	function automatic logic [15:0] boundary_us(input int k);
		case (k)
			0:  return 16'd0;
			1:  return 16'(ZERO_LO);
			2:  return 16'(ZERO_LO + 1);
			3:  return 16'(ZERO_HI - 1);
			4:  return 16'(ZERO_HI);
			5:  return 16'(ONE_LO);
			6:  return 16'(ONE_LO + 1);
			7:  return 16'(ONE_HI - 1);
			8:  return 16'(ONE_HI);
			9:  return 16'(REPEAT_LO);
			10: return 16'(REPEAT_LO + 1);
			11: return 16'(LEADER_LO - 1);
			12: return 16'(LEADER_LO);
			13: return 16'(LEADER_LO + 1);
			14: return 16'(LEADER_HI - 1);
			15: return 16'(LEADER_HI);
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [15:0] noise_us();
		if ($urandom_range(1))
			return boundary_us($urandom_range(16));
		return 16'($urandom);
	endfunction

	task automatic send_item(input in_item_t it);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	task automatic send_edge(input logic [15:0] us);
		in_item_t it;
		it.func          = 1'b0;
		it.interval_us   = us;
		it.display_mode  = 1'($urandom_range(1));
		it.standby       = 1'($urandom_range(1));
		it.repeat_enable = ($urandom_range(3) != 0);
		send_item(it);
	endtask

	task automatic send_tick();
		in_item_t it;
		it.func          = 1'b1;
		it.interval_us   = 16'($urandom);
		it.display_mode  = 1'($urandom_range(1));
		it.standby       = 1'($urandom_range(1));
		it.repeat_enable = 1'($urandom_range(1));
		send_item(it);
	endtask

	task automatic send_bit(input logic b);
		send_edge(b ? pick_between(ONE_LO, ONE_HI) : pick_between(ZERO_LO, ZERO_HI));
	endtask

	// leader plus 32 bits, LSB first; a corrupt frame has one slot replaced by noise
	task automatic send_frame(input logic [15:0] addr, input logic [7:0] data,
			input logic [7:0] inv, input logic corrupt);
		logic [31:0] word;
		int bad_slot;
		word     = {inv, data, addr};
		bad_slot = corrupt ? $urandom_range(31) : 32;
		send_edge(pick_between(LEADER_LO, LEADER_HI));
		for (int i = 0; i < 32; i++) begin
			if (i == bad_slot)
				send_edge(noise_us());
			else
				send_bit(word[i]);
		end
	endtask

	task automatic hold_key(input int n_rep);
		for (int r = 0; r < n_rep; r++) begin
			send_edge(pick_between(REPEAT_LO, LEADER_LO));
			if ($urandom_range(9) >= 7)
				repeat ($urandom_range(1, 3)) send_tick();
		end
	endtask

	task automatic release_wait();
		int div;
		div = (regs.divide == 0) ? 1 : int'(regs.divide);
		repeat (div * (int'(regs.rel_ticks) + 1) + 1) send_tick();
	endtask

	task automatic random_episode();
		int pick;
		int n_rep;
		logic [15:0] addr;
		logic [7:0] data;
		logic [7:0] inv;
		pick = $urandom_range(99);
		if (pick < 60) begin
			addr = ($urandom_range(9) != 0) ? regs.custom : 16'($urandom);
			data = ($urandom_range(9) < 7) ? 8'($urandom_range(MAPPED_LO, MAPPED_HI))
				: 8'($urandom);
			inv = ($urandom_range(9) != 0) ? ~data : 8'($urandom);
			send_frame(addr, data, inv, $urandom_range(9) == 0);
			case ($urandom_range(3))
				0, 1: n_rep = $urandom_range(0, 4);
				2: n_rep = int'(regs.threshold) + $urandom_range(1, 3);
				default: n_rep = int'(regs.long_press) + $urandom_range(0, 2);
			endcase
			hold_key(cap_reps(n_rep));
			if ($urandom_range(1))
				release_wait();
			else
				repeat ($urandom_range(0, 6)) send_tick();
		end else if (pick < 75) begin
			// frame cut short
			send_edge(pick_between(LEADER_LO, LEADER_HI));
			repeat ($urandom_range(0, 31)) send_bit(1'($urandom_range(1)));
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(3) == 0)
					send_tick();
				else
					send_edge(noise_us());
			end
		end else begin
			hold_key($urandom_range(1, 4));
		end
	endtask

	// stop sending and let every predicted event come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(input reg_set_t s);
		write_reg(REG_CUSTOM_CODE, s.custom);
		write_reg(REG_RELEASE_TICKS, 16'(s.rel_ticks));
		write_reg(REG_TICK_DIVIDE, 16'(s.divide));
		write_reg(REG_LONG_PRESS, 16'(s.long_press));
		write_reg(REG_REPEAT_THRESH, 16'(s.threshold));
		cfg_valid <= 1'b0;
		regs = s;
	endtask

	initial begin
		reg_set_t plan[N_PHASES];
		int phase_start;

		plan[0] = '{custom: 16'hFF80, rel_ticks: 4'd8, divide: 5'd18,
			long_press: 8'd20, threshold: 8'd2};
		plan[1] = '{custom: 16'h0000, rel_ticks: 4'd1, divide: 5'd31,
			long_press: 8'd1, threshold: 8'd0};
		plan[2] = '{custom: 16'hFFFF, rel_ticks: 4'd15, divide: 5'd1,
			long_press: 8'd255, threshold: 8'd255};
		plan[3] = '{custom: 16'($urandom), rel_ticks: 4'($urandom_range(2, 4)),
			divide: 5'($urandom_range(1, 3)), long_press: 8'($urandom_range(3, 8)),
			threshold: 8'($urandom_range(1, 3))};
		// a divide of zero behaves as one
		plan[4] = '{custom: 16'($urandom), rel_ticks: 4'd3, divide: 5'd0,
			long_press: 8'd2, threshold: 8'd1};
		plan[5] = '{custom: 16'($urandom), rel_ticks: 4'($urandom_range(1, 15)),
			divide: 5'($urandom_range(1, 4)), long_press: 8'($urandom_range(1, 20)),
			threshold: 8'($urandom_range(0, 10))};
		regs = plan[0];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			case (p / 2)
				0: begin
					send_idle = 15;
					recv_idle = 54;
				end
				1: begin
					send_idle = 54;
					recv_idle = 15;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			if (p == 0) begin
				// edges with no leader yet, on every class boundary, then a few ticks
				for (int k = 0; k <= 16; k++)
					send_edge(boundary_us(k));
				repeat (4) send_tick();
			end else begin
				load_regs(plan[p]);
			end
			phase_start = items_sent;
			// a clean left press run into auto-repeat, then power held to long press
			send_frame(regs.custom, CODE_LEFT, ~CODE_LEFT, 1'b0);
			hold_key(cap_reps(int'(regs.threshold) + 2));
			send_frame(regs.custom, CODE_POWER, ~CODE_POWER, 1'b0);
			hold_key(cap_reps(int'(regs.long_press) + 1));
			release_wait();
			while (items_sent - phase_start < PHASE_ITEMS) begin
				random_episode();
				if ($urandom_range(29) == 0)
					drain();
			end
			drain();
		end

		$display("sent %0d requests over %0d register settings and three stall patterns",
			items_sent, N_PHASES);
		$display("checked %0d key events: frames, repeats, auto-repeat, long press, releases",
			events_seen);
		if (fails == 0 && waiting == 0)
			$display("nec_ir_remote_decoder_tb: PASS");
		else
			$display("nec_ir_remote_decoder_tb: FAIL");
		$finish;
	end

endmodule
